>>> hw/rtl/wgm_pkg.sv
`timescale 1ns / 1ps

package wgm_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int REG_BYTES       = 16;
	localparam int LEN_W           = 5;
	localparam int CFG_W           = 64;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0] STAR_CODE  = 8'h2A;
	localparam logic [7:0] QUEST_CODE = 8'h3F;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_Z    = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef enum logic [1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_PAT_LEN = 2'd2,
		REG_CASE_IN = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       present;
		logic       last;
	} item_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ci);
		if (ci && (c >= LOWER_A) && (c <= LOWER_Z)) begin
			return c - CASE_DIFF;
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/wgm_fifo.sv
`timescale 1ns / 1ps

module wgm_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = wgm_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/wgm_front.sv
`timescale 1ns / 1ps

module wgm_front (
	input  logic          push,
	input  logic [7:0]    subject_byte,
	input  logic          byte_present,
	input  logic          last_byte,
	input  logic          case_in,
	input  logic          q_full,
	output logic          q_wr,
	output wgm_pkg::item_t q_item
);

	logic useful;

	// an item with no byte that does not end the subject changes nothing
	assign useful = byte_present || last_byte;
	assign q_wr   = push && !q_full && useful;

	always_comb begin
		q_item          = '0;
		q_item.byte_val = wgm_pkg::fold_byte(subject_byte, case_in);
		q_item.present  = byte_present;
		q_item.last     = last_byte;
	end

endmodule

>>> hw/rtl/wgm_back.sv
`timescale 1ns / 1ps

module wgm_back #(
	parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [wgm_pkg::CFG_W-1:0] pat_lo,
	input  logic [wgm_pkg::CFG_W-1:0] pat_hi,
	input  logic [wgm_pkg::LEN_W-1:0] pat_len,
	input  logic                      case_in,
	input  logic                      q_empty,
	input  wgm_pkg::item_t            q_item,
	output logic                      q_pop,
	input  logic                      res_full,
	output logic                      res_wr,
	output logic                      res_match
);

	localparam int N = (PATTERN_MAX < wgm_pkg::REG_BYTES) ? PATTERN_MAX : wgm_pkg::REG_BYTES;
	localparam int LW = wgm_pkg::LEN_W;

	function automatic logic [N:0] close_f(input logic [N:0] v, input logic [N-1:0] s);
		logic [N:0] r;
		logic       run;
		r = '0;
		for (int j = 0; j <= N; j++) begin
			run  = 1'b1;
			r[j] = v[j];
			for (int k = 1; k <= j; k++) begin
				run  = run & s[j-k];
				r[j] = r[j] | (v[j-k] & run);
			end
		end
		return r;
	endfunction

	logic [N:0]    act_q;
	logic          seen_q;
	logic [LW-1:0] ulen;
	logic [N:0]    keep;
	logic [N:0]    hit;
	logic [7:0]    pat [N];
	logic [N-1:0]  star;
	logic [N-1:0]  adv;
	logic [N:0]    cur;
	logic [N:0]    step;
	logic [N:0]    nxt;
	logic [N:0]    fin;
	logic          take;
	logic [63:0]   word;

	assign take  = !q_empty && (!q_item.last || !res_full);
	assign q_pop = take;

	always_comb begin
		word = '0;
		ulen = (pat_len > LW'(N)) ? LW'(N) : pat_len;
		for (int j = 0; j <= N; j++) begin
			keep[j] = (LW'(j) <= ulen);
			hit[j]  = (LW'(j) == ulen);
		end
		for (int i = 0; i < N; i++) begin
			word    = (i < 8) ? pat_lo : pat_hi;
			pat[i]  = wgm_pkg::fold_byte(word[(i % 8) * 8 +: 8], case_in);
			star[i] = (LW'(i) < ulen) && (pat[i] == wgm_pkg::STAR_CODE);
			adv[i]  = (LW'(i) < ulen) && (pat[i] != wgm_pkg::STAR_CODE)
				&& ((pat[i] == wgm_pkg::QUEST_CODE) || (pat[i] == q_item.byte_val));
		end
		cur  = close_f(act_q & keep, star);
		step = '0;
		for (int i = 0; i < N; i++) begin
			step[i]   = step[i] | (cur[i] & star[i]);
			step[i+1] = step[i+1] | (cur[i] & adv[i]);
		end
		nxt       = close_f(step & keep, star);
		fin       = q_item.present ? nxt : cur;
		res_match = (seen_q || q_item.present) && (ulen != '0) && (|(fin & hit));
	end

	assign res_wr = take && q_item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= (N+1)'(1);
			seen_q <= 1'b0;
		end else if (take) begin
			if (q_item.last) begin
				act_q  <= (N+1)'(1);
				seen_q <= 1'b0;
			end else if (q_item.present) begin
				act_q  <= nxt;
				seen_q <= 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
// path: a transaction is registered in the item queue and again in the
// result queue before its result shows on the result ports
// throughput: one subject byte per cycle while neither queue is full;
// the back end updates its active-position vector on each byte taken
// reset: arst_n clears queues, configuration and the match state at once

module wildcard_glob_matcher #(
	parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                subject_byte,
	input  logic                      byte_present,
	input  logic                      last_byte,
	output logic                      empty,
	input  logic                      pop,
	output logic                      matched,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [wgm_pkg::CFG_W-1:0] cfg_data
);

	localparam int IW = $bits(wgm_pkg::item_t);

	logic [wgm_pkg::CFG_W-1:0] pat_lo_q;
	logic [wgm_pkg::CFG_W-1:0] pat_hi_q;
	logic [wgm_pkg::LEN_W-1:0] pat_len_q;
	logic                      case_in_q;

	logic           q_wr;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	wgm_pkg::item_t q_wr_item;
	logic [IW-1:0]  q_rd_data;
	logic           res_wr;
	logic           res_full;
	logic           res_match;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= '0;
			case_in_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (wgm_pkg::cfg_reg_t'(cfg_index))
				wgm_pkg::REG_PAT_LO:  pat_lo_q  <= cfg_data;
				wgm_pkg::REG_PAT_HI:  pat_hi_q  <= cfg_data;
				wgm_pkg::REG_PAT_LEN: pat_len_q <= cfg_data[wgm_pkg::LEN_W-1:0];
				wgm_pkg::REG_CASE_IN: case_in_q <= cfg_data[0];
			endcase
		end
	end

	wgm_front u_front (
		.push         (push),
		.subject_byte (subject_byte),
		.byte_present (byte_present),
		.last_byte    (last_byte),
		.case_in      (case_in_q),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_item       (q_wr_item)
	);

	wgm_fifo #(
		.WIDTH (IW),
		.DEPTH (wgm_pkg::QUEUE_DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	wgm_back #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pat_lo    (pat_lo_q),
		.pat_hi    (pat_hi_q),
		.pat_len   (pat_len_q),
		.case_in   (case_in_q),
		.q_empty   (q_empty),
		.q_item    (wgm_pkg::item_t'(q_rd_data)),
		.q_pop     (q_pop),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res_match (res_match)
	);

	wgm_fifo #(
		.WIDTH (1),
		.DEPTH (wgm_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_match),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (matched),
		.empty   (empty)
	);

endmodule

>>> hw/rtl/wgm_checker.sv
`timescale 1ns / 1ps

module wgm_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic pop,
	input logic empty,
	input logic matched
);

	// queues come out of reset empty on both sides
	a_reset_state: assert property (@(posedge clk) $rose(arst_n) |-> (empty && !full))
		else $error("queues not clear under reset");

	// a waiting result that is not taken stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(!empty && !pop)) |-> (!empty && $stable(matched)))
		else $error("pending result lost or changed");

	// input side only fills up through a transaction
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without push");

	// result side only drains through a pop
	a_empty_cause: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $rose(empty)) |-> $past(pop))
		else $error("result vanished without pop");

endmodule

bind wildcard_glob_matcher wgm_checker u_chk (.*);
